>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, sampled on the rising clock edge, off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form of the same check.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> sv/aepc_pkg.sv
package aepc_pkg;

	localparam int NUM_CHANNELS = 128;
	localparam int BUFFER_DEPTH = 1024;

	localparam int ChW  = $clog2(NUM_CHANNELS);
	localparam int OccW = $clog2(BUFFER_DEPTH + 1);
	localparam int CfgW = 11;
	localparam int CntW = 32;

	typedef enum logic [1:0] {
		FUNC_ARRIVAL = 2'd0,
		FUNC_DEPART  = 2'd1,
		FUNC_READ    = 2'd2,
		FUNC_NONE    = 2'd3
	} func_t;

	localparam logic [1:0] CFG_EPD_THRESHOLD   = 2'd0;
	localparam logic [1:0] CFG_CLP1_THRESHOLD  = 2'd1;
	localparam logic [1:0] CFG_BUFFER_CAPACITY = 2'd2;

	// One per-VC table row: frame flags and the five wrapping counters.
	typedef struct packed {
		logic            frame_start;
		logic            frame_accept;
		logic [CntW-1:0] received;
		logic [CntW-1:0] received_clp0;
		logic [CntW-1:0] lost;
		logic [CntW-1:0] lost_clp0;
		logic [CntW-1:0] served;
	} vc_entry_t;

	localparam vc_entry_t EntryReset = '{
		frame_start:   1'b1,
		frame_accept:  1'b1,
		received:      '0,
		received_clp0: '0,
		lost:          '0,
		lost_clp0:     '0,
		served:        '0
	};

	// Outcome of one operation, from the update logic to the top level.
	typedef struct packed {
		logic accepted;
		logic dropped;
		logic vci_error;
		logic entry_we;
		logic show_counters;
	} aepc_res_t;

endpackage

>>> sv/aepc_ram.sv
module aepc_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/aepc_update.sv
module aepc_update import aepc_pkg::*; (
	input  func_t           func,
	input  logic            clp,
	input  logic            end_of_frame,
	input  logic            is_aal5,
	input  logic            vci_legal,
	input  vc_entry_t       entry,
	input  logic [OccW-1:0] occ,
	input  logic [CfgW-1:0] epd_threshold,
	input  logic [CfgW-1:0] clp1_threshold,
	input  logic [CfgW-1:0] buffer_capacity,
	output vc_entry_t       entry_new,
	output logic [OccW-1:0] occ_new,
	output aepc_res_t       res
);

	logic [31:0] occ_w;
	logic [31:0] cap_w;
	logic        room;
	logic        ok;

	// Room exists below min(capacity, depth).
	always_comb begin
		occ_w = 32'(occ);
		cap_w = (32'(buffer_capacity) > BUFFER_DEPTH) ? 32'(BUFFER_DEPTH) : 32'(buffer_capacity);
		room  = occ_w < cap_w;
	end

	always_comb begin
		entry_new = entry;
		occ_new   = occ;
		res       = '0;
		ok        = 1'b0;
		unique case (func)
			FUNC_ARRIVAL: begin
				if (!is_aal5) begin
					if (room) begin
						occ_new      = occ + 1'b1;
						res.accepted = 1'b1;
					end else begin
						res.dropped = 1'b1;
					end
				end else if (!vci_legal) begin
					res.vci_error = 1'b1;
				end else begin
					res.entry_we      = 1'b1;
					res.show_counters = 1'b1;
					entry_new.received = entry.received + 1'b1;
					if (!clp) begin
						entry_new.received_clp0 = entry.received_clp0 + 1'b1;
					end
					// First cell decides admission of the whole frame.
					if (entry.frame_start) begin
						entry_new.frame_start  = 1'b0;
						entry_new.frame_accept = occ_w < 32'(epd_threshold);
					end
					if (end_of_frame) begin
						entry_new.frame_start = 1'b1;
					end
					if (clp && occ_w > 32'(clp1_threshold)) begin
						entry_new.frame_accept = 1'b0;
					end
					ok = entry_new.frame_accept;
					if (ok && room) begin
						occ_new          = occ + 1'b1;
						entry_new.served = entry.served + 1'b1;
						res.accepted     = 1'b1;
					end else begin
						// Overflow discards the rest of the frame.
						entry_new.frame_accept = 1'b0;
						entry_new.lost         = entry.lost + 1'b1;
						if (!clp) begin
							entry_new.lost_clp0 = entry.lost_clp0 + 1'b1;
						end
						res.dropped = 1'b1;
					end
				end
			end
			FUNC_DEPART: begin
				if (occ != '0) begin
					occ_new = occ - 1'b1;
				end
			end
			FUNC_READ: begin
				if (!vci_legal) begin
					res.vci_error = 1'b1;
				end else begin
					res.show_counters = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> sv/atm_epd_ppd_clp_admission.sv
// ATM cell buffer admission: early packet discard, partial packet discard
// and a CLP=1 threshold over one shared queue occupancy count.
//
// Channels: the item channel (in_valid/in_ready) carries func, vci, clp,
// end_of_frame and is_aal5; the result channel (out_valid/out_ready) returns
// one result per item. The config channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data) writes epd_threshold, clp1_threshold and buffer_capacity; it is
// always ready, and an index beyond the list is ignored.
//
// Operation: the per-VC row is read from a single synchronous RAM when an item
// is transferred, then modified and written back in a second step, which
// also loads the output register. The input is not ready while an item sits
// in that second step, so reads never overlap a pending write, and no new
// item is taken before the last one leaves it.
//
// Reset clears occupancy, the output valid flag and one valid bit per VC; a
// row whose valid bit is clear reads as fresh (both frame flags set, counters
// zero), so no clearing pass is needed. A stalled receiver holds the result;
// one further item may be taken and waits in the second step until the
// output register frees.
module atm_epd_ppd_clp_admission import aepc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,

	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      func,
	input  logic [6:0]      vci,
	input  logic            clp,
	input  logic            end_of_frame,
	input  logic            is_aal5,

	output logic            out_valid,
	input  logic            out_ready,
	output logic            accepted,
	output logic            dropped,
	output logic            vci_error,
	output logic [10:0]     queue_length,
	output logic [CntW-1:0] received_count,
	output logic [CntW-1:0] received_clp0_count,
	output logic [CntW-1:0] lost_count,
	output logic [CntW-1:0] lost_clp0_count,
	output logic [CntW-1:0] served_count,

	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [CfgW-1:0] cfg_data
);

	`include "assert_macros.svh"

	// Configuration registers
	logic [CfgW-1:0] epd_threshold_q;
	logic [CfgW-1:0] clp1_threshold_q;
	logic [CfgW-1:0] buffer_capacity_q;

	// Shared state
	logic [OccW-1:0]         occ_q;
	logic [NUM_CHANNELS-1:0] row_valid_q;

	// Second step: item held while its row comes out of the RAM
	logic            valid_s1;
	func_t           func_s1;
	logic [ChW-1:0]  idx_s1;
	logic            legal_s1;
	logic            clp_s1;
	logic            eof_s1;
	logic            aal5_s1;
	logic            hit_s1;

	logic            in_xfer;
	logic            done_s1;
	logic            out_valid_q;
	logic            vci_legal;
	logic [ChW-1:0]  vci_idx;

	vc_entry_t       ram_rdata;
	vc_entry_t       entry_cur;
	vc_entry_t       entry_new;
	logic [OccW-1:0] occ_new;
	aepc_res_t       res;
	logic            ram_we;

	assign cfg_ready = 1'b1;
	assign in_ready  = !valid_s1;
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Finish the second step once the output register can take the result.
	assign done_s1 = valid_s1 && (!out_valid_q || out_ready);

	assign vci_legal = 32'(vci) < NUM_CHANNELS;
	assign vci_idx   = ChW'(vci);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epd_threshold_q   <= CfgW'(600);
			clp1_threshold_q  <= CfgW'(100);
			buffer_capacity_q <= CfgW'(1000);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_EPD_THRESHOLD:   epd_threshold_q   <= cfg_data;
				CFG_CLP1_THRESHOLD:  clp1_threshold_q  <= cfg_data;
				CFG_BUFFER_CAPACITY: buffer_capacity_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Per-VC rows: frame flags and counters in one RAM.
	aepc_ram #(
		.Width($bits(vc_entry_t)),
		.Depth(NUM_CHANNELS)
	) u_vc_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_s1),
		.wdata(entry_new),
		.re   (in_xfer),
		.raddr(vci_idx),
		.rdata(ram_rdata)
	);

	// A row never written since reset reads as fresh.
	assign entry_cur = hit_s1 ? ram_rdata : EntryReset;
	assign ram_we    = done_s1 && res.entry_we;

	aepc_update u_update (
		.func           (func_s1),
		.clp            (clp_s1),
		.end_of_frame   (eof_s1),
		.is_aal5        (aal5_s1),
		.vci_legal      (legal_s1),
		.entry          (entry_cur),
		.occ            (occ_q),
		.epd_threshold  (epd_threshold_q),
		.clp1_threshold (clp1_threshold_q),
		.buffer_capacity(buffer_capacity_q),
		.entry_new      (entry_new),
		.occ_new        (occ_new),
		.res            (res)
	);

	// Capture the item and the row's valid bit at transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (done_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_s1  <= func_t'(func);
			idx_s1   <= vci_idx;
			legal_s1 <= vci_legal;
			clp_s1   <= clp;
			eof_s1   <= end_of_frame;
			aal5_s1  <= is_aal5;
			hit_s1   <= row_valid_q[vci_idx];
		end
	end

	// Commit occupancy and mark the row written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			row_valid_q <= '0;
		end else if (done_s1) begin
			occ_q <= occ_new;
			if (res.entry_we) begin
				row_valid_q[idx_s1] <= 1'b1;
			end
		end
	end

	// Output register: load on completion, drop valid once transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1) begin
			accepted     <= res.accepted;
			dropped      <= res.dropped;
			vci_error    <= res.vci_error;
			queue_length <= 11'(occ_new);
			if (res.show_counters) begin
				received_count      <= entry_new.received;
				received_clp0_count <= entry_new.received_clp0;
				lost_count          <= entry_new.lost;
				lost_clp0_count     <= entry_new.lost_clp0;
				served_count        <= entry_new.served;
			end else begin
				received_count      <= '0;
				received_clp0_count <= '0;
				lost_count          <= '0;
				lost_clp0_count     <= '0;
				served_count        <= '0;
			end
		end
	end

	`ASSERT_CLK(a_occ_bound, clk, arst_n, 32'(occ_q) <= BUFFER_DEPTH, "occupancy above buffer depth")
	`ASSERT_CLK(a_occ_step, clk, arst_n, (occ_q == $past(occ_q)) || (occ_q == $past(occ_q) + 1'b1) || (occ_q == $past(occ_q) - 1'b1), "occupancy moved by more than one")
	`ASSERT_IMPL(a_flags_excl, clk, arst_n, out_valid_q, !(accepted && dropped), "result both accepted and dropped")
	`ASSERT_IMPL(a_we_in_step, clk, arst_n, ram_we, valid_s1 && !in_xfer, "row written outside the second step")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import aepc_pkg::*;

	localparam int HalfPeriod = 5;
	localparam int CycleLimit = 200000;
	localparam int HoldCycles = 300;
	localparam int PoolSize   = 8;
	localparam int DrainWait  = 4;

	// Index past the register list: the block must ignore a write to it.
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	// One result transfer, field for field.
	typedef struct packed {
		logic            accepted;
		logic            dropped;
		logic            vci_error;
		logic [10:0]     qlen;
		logic [CntW-1:0] received;
		logic [CntW-1:0] received_clp0;
		logic [CntW-1:0] lost;
		logic [CntW-1:0] lost_clp0;
		logic [CntW-1:0] served;
	} cell_result_t;

	// Directed rows: an item checked by the admission model, an item with its
	// result written out by hand, or a new set of limits.
	typedef enum {ROW_ITEM, ROW_TYPED, ROW_LIMITS} row_kind_t;

	typedef struct {
		row_kind_t kind;
		func_t     func;
		int        vci, clp, eof, aal5;
		int        epd, clp1, cap;
		int        acc, drp, qlen, rcv, rcv0, lost, lost0, srv;
	} stim_row_t;

	// Random phases: limits, item count and share of arrivals in percent.
	typedef struct {
		int epd, clp1, cap, count, arrival_pct;
	} phase_t;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             in_valid     = 1'b0;
	logic             in_ready;
	logic [1:0]       func         = FUNC_ARRIVAL;
	logic [6:0]       vci          = '0;
	logic             clp          = 1'b0;
	logic             end_of_frame = 1'b0;
	logic             is_aal5      = 1'b0;
	logic             out_valid;
	logic             out_ready    = 1'b0;
	logic             accepted;
	logic             dropped;
	logic             vci_error;
	logic [10:0]      queue_length;
	logic [CntW-1:0]  received_count;
	logic [CntW-1:0]  received_clp0_count;
	logic [CntW-1:0]  lost_count;
	logic [CntW-1:0]  lost_clp0_count;
	logic [CntW-1:0]  served_count;
	logic             cfg_valid    = 1'b0;
	logic             cfg_ready;
	logic [1:0]       cfg_index    = CFG_EPD_THRESHOLD;
	logic [CfgW-1:0]  cfg_data     = '0;

	// Admission state as the testbench sees it, at reset values.
	logic [CfgW-1:0]  epd_limit    = 11'd600;
	logic [CfgW-1:0]  clp1_limit   = 11'd100;
	logic [CfgW-1:0]  buf_cap      = 11'd1000;
	logic [10:0]      occupancy    = '0;
	logic             first_cell  [NUM_CHANNELS] = '{default: 1'b1};
	logic             frame_admit [NUM_CHANNELS] = '{default: 1'b1};
	logic [CntW-1:0]  rcv_cnt     [NUM_CHANNELS] = '{default: '0};
	logic [CntW-1:0]  rcv0_cnt    [NUM_CHANNELS] = '{default: '0};
	logic [CntW-1:0]  lost_cnt    [NUM_CHANNELS] = '{default: '0};
	logic [CntW-1:0]  lost0_cnt   [NUM_CHANNELS] = '{default: '0};
	logic [CntW-1:0]  srv_cnt     [NUM_CHANNELS] = '{default: '0};

	cell_result_t     outstanding[$];
	logic [6:0]       vc_pool [PoolSize];
	int               mismatches    = 0;
	int               cycle_count   = 0;
	bit               steady        = 1'b0;
	int               hold_requests = 0;
	int               holds_taken   = 0;
	int               hold_left     = 0;

	stim_row_t directed [27] = '{
		// after reset: empty departure, fresh counters, unused code, first arrivals
		'{ROW_TYPED,  FUNC_DEPART,    0, 0, 0, 0,    0,   0,    0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_TYPED,  FUNC_READ,    127, 0, 0, 1,    0,   0,    0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_TYPED,  FUNC_NONE,      5, 1, 1, 1,    0,   0,    0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_TYPED,  FUNC_ARRIVAL, 127, 1, 1, 0,    0,   0,    0, 1, 0, 1, 0, 0, 0, 0, 0},
		'{ROW_TYPED,  FUNC_ARRIVAL,   0, 0, 0, 1,    0,   0,    0, 1, 0, 2, 1, 1, 0, 0, 1},
		'{ROW_TYPED,  FUNC_ARRIVAL,   0, 1, 1, 1,    0,   0,    0, 1, 0, 3, 2, 1, 0, 0, 2},
		'{ROW_ITEM,   FUNC_READ,      0, 0, 0, 1,    0,   0,    0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM,   FUNC_ARRIVAL, 127, 1, 0, 1,    0,   0,    0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM,   FUNC_DEPART,   64, 0, 0, 0,    0,   0,    0, 0, 0, 0, 0, 0, 0, 0, 0},
		// tight limits: CLP=1 discard, early discard, full buffer
		'{ROW_LIMITS, FUNC_NONE,      0, 0, 0, 0,    4,   1,    5, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM,   FUNC_ARRIVAL,   3, 0, 0, 1,    0,   0,    0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM,   FUNC_ARRIVAL,   3, 1, 0, 1,    0,   0,    0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM,   FUNC_ARRIVAL,   3, 0, 1, 1,    0,   0,    0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM,   FUNC_ARRIVAL,   4, 0, 0, 1,    0,   0,    0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM,   FUNC_ARRIVAL,   4, 0, 1, 1,    0,   0,    0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM,   FUNC_ARRIVAL,  85, 0, 0, 0,    0,   0,    0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM,   FUNC_ARRIVAL,  85, 1, 1, 0,    0,   0,    0, 0, 0, 0, 0, 0, 0, 0, 0},
		// partial discard: overflow kills the rest of the frame
		'{ROW_LIMITS, FUNC_NONE,      0, 0, 0, 0, 1024, 1024,   5, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM,   FUNC_ARRIVAL,   9, 0, 0, 1,    0,   0,    0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM,   FUNC_DEPART,    9, 0, 0, 1,    0,   0,    0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM,   FUNC_ARRIVAL,   9, 0, 1, 1,    0,   0,    0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM,   FUNC_READ,      9, 0, 0, 0,    0,   0,    0, 0, 0, 0, 0, 0, 0, 0, 0},
		// zero capacity admits nothing; an oversized one is clipped
		'{ROW_LIMITS, FUNC_NONE,      0, 0, 0, 0, 1024, 1024,   0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM,   FUNC_ARRIVAL,  42, 0, 0, 0,    0,   0,    0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_LIMITS, FUNC_NONE,      0, 0, 0, 0, 2047,   0, 2047, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM,   FUNC_ARRIVAL,  85, 0, 0, 0,    0,   0,    0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM,   FUNC_ARRIVAL,  42, 1, 1, 1,    0,   0,    0, 0, 0, 0, 0, 0, 0, 0, 0}
	};

	// Phases are ordered so occupancy drifts through each threshold set:
	// low limits first, then a build-up above the CLP1 threshold, then a
	// departure-heavy drain before the last two small settings.
	phase_t phases [7] = '{
		'{  12,    6,   16, 150, 60},
		'{   1,    1,    1,  80, 50},
		'{1024, 1024, 1024, 100, 50},
		'{ 600,  100, 1000, 250, 80},
		'{2047,    0, 2047, 170, 15},
		'{  30,   50,   25, 150, 55},
		'{  40,   20,   60, 120, 60}
	};

	atm_epd_ppd_clp_admission uut (.*);

	always #(HalfPeriod) clk = ~clk;

	// Copy a channel's five counters into a result.
	function automatic void fill_counters(input logic [6:0] ch, inout cell_result_t r);
		r.received      = rcv_cnt[ch];
		r.received_clp0 = rcv0_cnt[ch];
		r.lost          = lost_cnt[ch];
		r.lost_clp0     = lost0_cnt[ch];
		r.served        = srv_cnt[ch];
	endfunction

	// Apply one operation to the admission state and return its result.
	function automatic cell_result_t admission_outcome(input func_t f, input logic [6:0] ch,
			input logic c, input logic e, input logic a);
		cell_result_t r;
		logic [10:0]  room_limit;
		logic         room;
		r = '0;
		room_limit = (buf_cap > BUFFER_DEPTH) ? 11'(BUFFER_DEPTH) : buf_cap;
		room = occupancy < room_limit;
		case (f)
			FUNC_ARRIVAL: begin
				if (!a) begin
					// plain item: no per-VC handling, just room
					if (room) begin
						occupancy++;
						r.accepted = 1'b1;
					end else begin
						r.dropped = 1'b1;
					end
				end else if (int'(ch) >= NUM_CHANNELS) begin
					r.vci_error = 1'b1;
				end else begin
					rcv_cnt[ch]++;
					if (!c) rcv0_cnt[ch]++;
					// first cell decides the whole frame
					if (first_cell[ch]) begin
						first_cell[ch] = 1'b0;
						frame_admit[ch] = occupancy < epd_limit;
					end
					if (e) first_cell[ch] = 1'b1;
					if (c && occupancy > clp1_limit) frame_admit[ch] = 1'b0;
					if (frame_admit[ch] && room) begin
						occupancy++;
						srv_cnt[ch]++;
						r.accepted = 1'b1;
					end else begin
						// overflow drops the rest of the frame as well
						frame_admit[ch] = 1'b0;
						lost_cnt[ch]++;
						if (!c) lost0_cnt[ch]++;
						r.dropped = 1'b1;
					end
					fill_counters(ch, r);
				end
			end
			FUNC_DEPART: begin
				if (occupancy != 0) occupancy--;
			end
			FUNC_READ: begin
				if (int'(ch) >= NUM_CHANNELS) r.vci_error = 1'b1;
				else fill_counters(ch, r);
			end
			default: ;
		endcase
		r.qlen = occupancy;
		return r;
	endfunction

	// Offer one item, hold it until the transfer, then log what it must return.
	task automatic offer_cell(input func_t f, input logic [6:0] ch, input logic c,
			input logic e, input logic a, input logic typed, input cell_result_t typed_res);
		cell_result_t r;
		@(negedge clk);
		if (!steady && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		in_valid     <= 1'b1;
		func         <= f;
		vci          <= ch;
		clp          <= c;
		end_of_frame <= e;
		is_aal5      <= a;
		do @(posedge clk); while (!in_ready);
		r = admission_outcome(f, ch, c, e, a);
		outstanding.push_back(typed ? typed_res : r);
	endtask

	// Drop valid and wait for every outstanding result plus the pipeline tail.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding.size() != 0) @(posedge clk);
		repeat (DrainWait) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CfgW-1:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_EPD_THRESHOLD:   epd_limit  = val[CfgW-1:0];
			CFG_CLP1_THRESHOLD:  clp1_limit = val[CfgW-1:0];
			CFG_BUFFER_CAPACITY: buf_cap    = val[CfgW-1:0];
			default: ;
		endcase
	endtask

	// Write all three limits back to back, then release the config channel.
	task automatic program_limits(input int epd, input int clp1, input int cap);
		write_reg(CFG_EPD_THRESHOLD, epd);
		write_reg(CFG_CLP1_THRESHOLD, clp1);
		write_reg(CFG_BUFFER_CAPACITY, cap);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Result side: random back-pressure, plus one long hold-off on request.
	// The hold is counted here so the sender keeps offering meanwhile.
	always @(negedge clk) begin
		if (hold_requests != holds_taken) begin
			holds_taken = hold_requests;
			hold_left = HoldCycles;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= 34);
		end
	end

	// Compare every result transfer with the oldest outstanding one.
	always @(posedge clk) begin
		cell_result_t want;
		if (out_valid && out_ready) begin
			if (outstanding.size() == 0) begin
				$display("%0t ns: result transfer with none outstanding", $time);
				mismatches++;
			end else begin
				want = outstanding.pop_front();
				check_field("accepted", want.accepted, accepted);
				check_field("dropped", want.dropped, dropped);
				check_field("vci_error", want.vci_error, vci_error);
				check_field("queue_length", want.qlen, queue_length);
				check_field("received_count", want.received, received_count);
				check_field("received_clp0_count", want.received_clp0, received_clp0_count);
				check_field("lost_count", want.lost, lost_count);
				check_field("lost_clp0_count", want.lost_clp0, lost_clp0_count);
				check_field("served_count", want.served, served_count);
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		stim_row_t    row;
		cell_result_t typed;
		func_t        f;
		logic [6:0]   ch;
		logic         c, e, a;
		int           rnd, mix;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table: hand-written results where obvious, model elsewhere.
		foreach (directed[i]) begin
			row = directed[i];
			if (row.kind == ROW_LIMITS) begin
				settle();
				program_limits(row.epd, row.clp1, row.cap);
			end else begin
				typed = '0;
				typed.accepted      = row.acc[0];
				typed.dropped       = row.drp[0];
				typed.qlen          = 11'(row.qlen);
				typed.received      = row.rcv;
				typed.received_clp0 = row.rcv0;
				typed.lost          = row.lost;
				typed.lost_clp0     = row.lost0;
				typed.served        = row.srv;
				offer_cell(row.func, 7'(row.vci), row.clp[0], row.eof[0], row.aal5[0],
					row.kind == ROW_TYPED, typed);
			end
		end

		// Random phases: framed AAL5 traffic on a small VC pool, mixed with
		// plain items, stray channels, departures, reads and the unused code.
		foreach (phases[p]) begin
			settle();
			if (p == 0) write_reg(CFG_UNUSED, 2047);
			program_limits(phases[p].epd, phases[p].clp1, phases[p].cap);
			foreach (vc_pool[k]) vc_pool[k] = 7'($urandom_range(127));
			steady = (p == 2);
			if (p == 3) hold_requests++;
			repeat (phases[p].count) begin
				rnd = $urandom_range(99);
				if (rnd < phases[p].arrival_pct) begin
					f   = FUNC_ARRIVAL;
					mix = $urandom_range(99);
					a   = (mix >= 10);
					ch  = (mix < 15) ? 7'($urandom_range(127)) : vc_pool[$urandom_range(PoolSize - 1)];
					c   = ($urandom_range(99) < 30);
					e   = ($urandom_range(99) < 25);
				end else begin
					f  = (rnd < 93) ? FUNC_DEPART : (rnd < 98) ? FUNC_READ : FUNC_NONE;
					ch = $urandom_range(1) ? vc_pool[$urandom_range(PoolSize - 1)]
						: 7'($urandom_range(127));
					c  = 1'($urandom_range(1));
					e  = 1'($urandom_range(1));
					a  = 1'($urandom_range(1));
				end
				offer_cell(f, ch, c, e, a, 1'b0, '0);
			end
		end
		steady = 1'b0;

		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
